/* rtl/q6k_pkg.sv */
// Shared types, opcodes and float helper functions for the Q6_K x Q8_K dot product.
// No dependencies; imported by q6k_ctrl, q6k_dp and the top level.
package q6k_pkg;

    // Float step sequence: one step per op
    typedef enum logic [1:0] {
        OP_D    = 2'd0,   // weight scale times activation scale
        OP_CVT  = 2'd1,   // block integer sum to float
        OP_PROD = 2'd2,   // scale product times converted sum
        OP_ADD  = 2'd3    // row accumulate
    } fop_t;

    // Controller states, one-hot
    typedef enum logic [4:0] {
        ST_RUN  = 5'b00001,
        ST_LOAD = 5'b00010,
        ST_NORM = 5'b00100,
        ST_RND  = 5'b01000,
        ST_OUTW = 5'b10000
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic load;
        logic norm;
        logic rnd;
        logic emit;
        fop_t op;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic norm_done;
        logic out_busy;
    } dp_stat_t;

    // Unpacked float operand: value = man * 2^ex (ex two's complement)
    typedef struct packed {
        logic        sgn;
        logic        nan;
        logic        inf;
        logic        zero;
        logic [23:0] man;
        logic [11:0] ex;
    } unp_t;

    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

    function automatic unp_t unpack_single(input logic [31:0] f);
        unp_t u;
        u.sgn  = f[31];
        u.nan  = (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
        u.inf  = (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
        u.zero = (f[30:23] == 8'h00) && (f[22:0] == 23'd0);
        u.man  = {(f[30:23] != 8'h00), f[22:0]};
        u.ex   = (f[30:23] == 8'h00) ? 12'hF6B : ({4'b0, f[30:23]} - 12'd150);
        return u;
    endfunction

    function automatic unp_t unpack_half(input logic [15:0] h);
        unp_t u;
        u.sgn  = h[15];
        u.nan  = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
        u.inf  = (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
        u.zero = (h[14:10] == 5'h00) && (h[9:0] == 10'd0);
        u.man  = {13'b0, (h[14:10] != 5'h00), h[9:0]};
        u.ex   = (h[14:10] == 5'h00) ? 12'hFE8 : ({7'b0, h[14:10]} - 12'd25);
        return u;
    endfunction

    // Right shift by sh (0..63) with lost bits ORed into bit 0
    function automatic logic [63:0] shr_sticky(input logic [63:0] x, input logic [5:0] sh);
        logic [63:0] mask;
        mask = (64'd1 << sh) - 64'd1;
        return (x >> sh) | {63'b0, |(x & mask)};
    endfunction

endpackage

/* rtl/q6k_ctrl.sv */
// Sequencing state machine: runs the integer stream and the per-block float steps.
// Depends on q6k_pkg; drives q6k_dp through dp_cmd_t and reads dp_stat_t.
module q6k_ctrl
    import q6k_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     end_of_block,
    input  logic     end_of_row,
    input  dp_stat_t stat,
    output logic     in_stall,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;
    fop_t   phase_reg, phase_next;
    logic   row_reg, row_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        row_next   = row_reg;
        cmd        = '0;
        cmd.op     = phase_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                cmd.accept = in_valid;
                if (in_valid && (end_of_block || end_of_row))
                begin
                    row_next   = end_of_row;
                    phase_next = OP_D;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                cmd.norm = 1'b1;
                if (stat.norm_done)
                    state_next = ST_RND;
            end
            ST_RND:
            begin
                cmd.rnd = 1'b1;
                if (phase_reg == OP_ADD)
                    state_next = row_reg ? ST_OUTW : ST_RUN;
                else
                begin
                    phase_next = fop_t'(phase_reg + 2'd1);
                    state_next = ST_LOAD;
                end
            end
            ST_OUTW:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    assign in_stall = (state_reg != ST_RUN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            phase_reg <= OP_D;
            row_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            row_reg   <= row_next;
        end
    end

endmodule

/* rtl/q6k_dp.sv */
// Datapath: two-stage integer multiply-accumulate, shared float multiply/add/normalize/round
// unit, row accumulator and output register. Depends on q6k_pkg.
module q6k_dp
    import q6k_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic [7:0]  low_nibbles_a,
    input  logic [7:0]  low_nibbles_b,
    input  logic [7:0]  high_bits,
    input  logic [31:0] act_bytes,
    input  logic [31:0] scale_bytes,
    input  logic [15:0] weight_scale_half,
    input  logic [31:0] act_scale_single,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] row_sum
);

    // Integer stage registers
    logic signed [13:0] sw_reg [4];
    logic signed [13:0] sw_next [4];
    logic signed [7:0]  act_reg [4];
    logic               st1_valid_reg;
    logic [31:0]        blk_sum_reg;
    logic [15:0]        lows;
    logic [5:0]         q [4];
    logic signed [5:0]  w [4];
    logic signed [21:0] p2 [4];
    logic signed [23:0] grp_sum;

    // Float registers
    logic [15:0] ws_reg;
    logic [31:0] as_reg, opa_reg, opb_reg, acc_reg;
    logic [63:0] m_reg, ld_m;
    logic [11:0] e_reg, ld_e;
    logic        s_reg, ld_s;
    logic        spec_reg, ld_spec;
    logic [31:0] spec_bits_reg, ld_bits;
    logic        out_valid_reg;
    logic [31:0] out_reg;

    // Load-step wires
    unp_t        ua, ub, big, sml;
    logic [47:0] mul_p;
    logic [11:0] diff;
    logic [63:0] xb, xs0, xs, asum, adif_ab, adif_ba;
    logic [31:0] mag;

    // Round-step wires
    logic [11:0] be, ef, sh;
    logic [63:0] mm;
    logic [24:0] r;
    logic [31:0] rnd_bits;
    logic [31:0] emit_bits;

    // Weight rebuild and first multiply
    assign lows = {low_nibbles_b[7:4], low_nibbles_a[7:4], low_nibbles_b[3:0], low_nibbles_a[3:0]};
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            q[k]       = {high_bits[2*k +: 2], lows[4*k +: 4]};
            w[k]       = {~q[k][5], q[k][4:0]};   // q - 32
            sw_next[k] = $signed(scale_bytes[8*k +: 8]) * w[k];
        end
    end

    // Second multiply and group sum
    always_comb
    begin
        grp_sum = '0;
        for (int k = 0; k < 4; k++)
        begin
            p2[k]   = sw_reg[k] * act_reg[k];
            grp_sum = grp_sum + 24'(p2[k]);
        end
    end

    // Operand selection for the shared float unit
    always_comb
    begin
        case (cmd.op)
            OP_D:
            begin
                ua = unpack_half(ws_reg);
                ub = unpack_single(as_reg);
            end
            OP_PROD:
            begin
                ua = unpack_single(opa_reg);
                ub = unpack_single(opb_reg);
            end
            default:
            begin
                ua = unpack_single(acc_reg);
                ub = unpack_single(opb_reg);
            end
        endcase
    end

    assign mul_p = ua.man * ub.man;
    assign mag   = blk_sum_reg[31] ? (32'd0 - blk_sum_reg) : blk_sum_reg;

    // Add alignment: larger exponent keeps its place, smaller shifts with sticky
    always_comb
    begin
        if ($signed(ua.ex) >= $signed(ub.ex))
        begin
            big = ua;
            sml = ub;
        end
        else
        begin
            big = ub;
            sml = ua;
        end
        diff = big.ex - sml.ex;
        xb   = {2'b0, big.man, 38'b0};
        xs0  = {2'b0, sml.man, 38'b0};
        if (diff >= 12'd64)
            xs = {63'b0, |sml.man};
        else
            xs = shr_sticky(xs0, diff[5:0]);
        asum    = xb + xs;
        adif_ab = xb - xs;
        adif_ba = xs - xb;
    end

    // Load step: exact result into m/e/s, or a special value
    always_comb
    begin
        ld_m    = '0;
        ld_e    = '0;
        ld_s    = 1'b0;
        ld_spec = 1'b0;
        ld_bits = QNAN_BITS;
        case (cmd.op)
            OP_CVT:
            begin
                ld_m = {32'b0, mag};
                ld_s = blk_sum_reg[31];
            end
            OP_ADD:
            begin
                if (ua.nan || ub.nan || (ua.inf && ub.inf && (ua.sgn != ub.sgn)))
                    ld_spec = 1'b1;
                else if (ua.inf || ub.inf)
                begin
                    ld_spec = 1'b1;
                    ld_bits = {(ua.inf ? ua.sgn : ub.sgn), 8'hFF, 23'd0};
                end
                ld_e = big.ex - 12'd38;
                if (ua.sgn == ub.sgn)
                begin
                    ld_m = asum;
                    ld_s = ua.sgn;
                end
                else if (xb >= xs)
                begin
                    ld_m = adif_ab;
                    ld_s = big.sgn;
                end
                else
                begin
                    ld_m = adif_ba;
                    ld_s = sml.sgn;
                end
                // exact zero: +0 unless both operands negative
                if (ld_m == 64'd0)
                    ld_s = ua.sgn & ub.sgn;
            end
            default:
            begin
                // multiply, for both scale product and final product
                ld_s = ua.sgn ^ ub.sgn;
                if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf))
                    ld_spec = 1'b1;
                else if (ua.inf || ub.inf)
                begin
                    ld_spec = 1'b1;
                    ld_bits = {ua.sgn ^ ub.sgn, 8'hFF, 23'd0};
                end
                ld_m = {16'b0, mul_p};
                ld_e = ua.ex + ub.ex;
            end
        endcase
    end

    assign stat.norm_done = spec_reg || m_reg[63] || (m_reg == 64'd0);
    assign stat.out_busy  = out_valid_reg && out_stall;

    // Round to nearest even and pack
    always_comb
    begin
        be = e_reg + 12'd190;   // leading bit at 63, plus bias
        sh = 12'd1 - be;
        if (!be[11] && (be != 12'd0))
            mm = m_reg;
        else if (sh >= 12'd64)
            mm = {63'b0, |m_reg};
        else
            mm = shr_sticky(m_reg, sh[5:0]);
        r  = {1'b0, mm[63:40]} + {24'b0, mm[39] & ((|mm[38:0]) | mm[40])};
        ef = be + {11'b0, r[24]};
        if (spec_reg)
            rnd_bits = spec_bits_reg;
        else if (m_reg == 64'd0)
            rnd_bits = {s_reg, 31'd0};
        else if (be[11] || (be == 12'd0))
            rnd_bits = {s_reg, 7'd0, r[23], r[22:0]};
        else if ($signed(ef) >= 12'sd255)
            rnd_bits = {s_reg, 8'hFF, 23'd0};
        else
            rnd_bits = {s_reg, ef[7:0], r[22:0]};
    end

    assign emit_bits = ((acc_reg[30:23] == 8'hFF) && (acc_reg[22:0] != 23'd0)) ?
                       QNAN_BITS : acc_reg;

    // Control and accumulator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            blk_sum_reg   <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st1_valid_reg <= cmd.accept;
            if (cmd.load && (cmd.op == OP_CVT))
                blk_sum_reg <= '0;
            else if (st1_valid_reg)
                blk_sum_reg <= blk_sum_reg + 32'(grp_sum);
            if (cmd.emit)
                acc_reg <= '0;
            else if (cmd.rnd && (cmd.op == OP_ADD))
                acc_reg <= rnd_bits;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            for (int k = 0; k < 4; k++)
            begin
                sw_reg[k]  <= sw_next[k];
                act_reg[k] <= $signed(act_bytes[8*k +: 8]);
            end
            ws_reg <= weight_scale_half;
            as_reg <= act_scale_single;
        end
        if (cmd.load)
        begin
            m_reg         <= ld_m;
            e_reg         <= ld_e;
            s_reg         <= ld_s;
            spec_reg      <= ld_spec;
            spec_bits_reg <= ld_bits;
        end
        else if (cmd.norm && !stat.norm_done)
        begin
            if (m_reg[63:48] == 16'd0)
            begin
                m_reg <= m_reg << 16;
                e_reg <= e_reg - 12'd16;
            end
            else
            begin
                m_reg <= m_reg << 1;
                e_reg <= e_reg - 12'd1;
            end
        end
        if (cmd.rnd && (cmd.op == OP_D))
            opa_reg <= rnd_bits;
        if (cmd.rnd && ((cmd.op == OP_CVT) || (cmd.op == OP_PROD)))
            opb_reg <= rnd_bits;
        if (cmd.emit)
            out_reg <= emit_bits;
    end

    assign out_valid = out_valid_reg;
    assign row_sum   = out_reg;

endmodule

/* rtl/q6k_q8k_quantized_dot_product.sv */
// Top level of the Q6_K x Q8_K quantized dot product: controller plus datapath.
// Depends on q6k_pkg, q6k_ctrl, q6k_dp.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_stall   | nibbles, high bits, acts, scales, fp scales, ends
//  out     | out_valid / out_stall | row_sum (fp32 bits)
//
// Items without a block or row end stream back to back.
// An item closing a block or row stalls input for four float steps on the shared
// multiply/add/round unit, each a load, a normalize and a round step, and a row end
// also waits to place its result in the output register.
// A waiting row result does not stop input; only the next row's emit waits for it.
// Reset clears the block sum, the row accumulator and all handshake state.
module q6k_q8k_quantized_dot_product
    import q6k_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  low_nibbles_a,
    input  logic [7:0]  low_nibbles_b,
    input  logic [7:0]  high_bits,
    input  logic [31:0] act_bytes,
    input  logic [31:0] scale_bytes,
    input  logic [15:0] weight_scale_half,
    input  logic [31:0] act_scale_single,
    input  logic        end_of_block,
    input  logic        end_of_row,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] row_sum
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    q6k_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .end_of_block (end_of_block),
        .end_of_row   (end_of_row),
        .stat         (stat),
        .in_stall     (in_stall),
        .cmd          (cmd)
    );

    q6k_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .low_nibbles_a     (low_nibbles_a),
        .low_nibbles_b     (low_nibbles_b),
        .high_bits         (high_bits),
        .act_bytes         (act_bytes),
        .scale_bytes       (scale_bytes),
        .weight_scale_half (weight_scale_half),
        .act_scale_single  (act_scale_single),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .row_sum           (row_sum)
    );

    // Items are taken only while the input is open
    a_accept_open: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !in_stall)
        else $error("item taken while input stalled");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid && out_stall))
        else $error("row result overwritten");

    // Emit always shows a result next cycle
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid)
        else $error("emitted row result not shown");

    // At most one datapath command per cycle
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.load, cmd.norm, cmd.rnd, cmd.emit}))
        else $error("conflicting datapath commands");

endmodule
